### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the record list block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another in the same cycle
`define ASSERT_SAME(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// Check that a condition implies another in the next cycle
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

### design/brlmf_pkg.sv
// ----------------------------------------------------------------------------
// brlmf_pkg
// Shared codes, widths and types of the bounded record list.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package brlmf_pkg;

	// Default list capacity
	localparam int CAPACITY_DEF = 256;

	// Field widths
	localparam int OP_W     = 3;
	localparam int TAG_W    = 16;
	localparam int NODE_W   = 16;
	localparam int COST_W   = 24;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 9;

	// Operation codes
	localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
	localparam logic [OP_W-1:0] OP_FIND   = 3'd2;
	localparam logic [OP_W-1:0] OP_MIN    = 3'd3;
	localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

	// Result status codes
	localparam logic [STATUS_W-1:0] STAT_DONE = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_MISS = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL = 2'd2;

	// One stored record
	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic [NODE_W-1:0] node;
		logic [COST_W-1:0] cost;
	} brlmf_rec_t;

	localparam int REC_W = $bits(brlmf_rec_t);

	// Result handed from the sequencer to the output register
	typedef struct packed {
		logic                valid;
		logic [STATUS_W-1:0] status;
		logic [TAG_W-1:0]    tag;
		logic [NODE_W-1:0]   node;
		logic [COST_W-1:0]   cost;
		logic [COUNT_W-1:0]  count;
	} brlmf_rsp_t;

endpackage

### design/brlmf_ram.sv
// ----------------------------------------------------------------------------
// brlmf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module brlmf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port, hold data when idle
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### design/brlmf_seq.sv
// ----------------------------------------------------------------------------
// brlmf_seq
// Operation sequencer: holds the entry count, drives the record RAM and
// scans it one entry per cycle for find, remove and minimum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module brlmf_seq #(
	parameter int CAPACITY = brlmf_pkg::CAPACITY_DEF,
	parameter int AW       = $clog2(CAPACITY),
	parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// request side
	input  logic                          req_take,
	input  logic [brlmf_pkg::OP_W-1:0]    op,
	input  logic [brlmf_pkg::TAG_W-1:0]   record_tag,
	input  logic [brlmf_pkg::NODE_W-1:0]  node_id,
	input  logic [brlmf_pkg::COST_W-1:0]  cost,
	output logic                          busy,
	// result side
	output brlmf_pkg::brlmf_rsp_t         rsp,
	input  logic                          rsp_take,
	// record RAM port
	output logic                          ram_we,
	output logic [AW-1:0]                 ram_waddr,
	output logic [brlmf_pkg::REC_W-1:0]   ram_wdata,
	output logic                          ram_re,
	output logic [AW-1:0]                 ram_raddr,
	input  logic [brlmf_pkg::REC_W-1:0]   ram_rdata
);

	import brlmf_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_MVRD = 3'd2;
	localparam logic [2:0] S_MVWR = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;

	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	// control state
	logic [2:0]       state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] iss_q;
	logic             vld_s1;
	logic             has_best_q;

	// payload state
	logic [OP_W-1:0]     op_q;
	logic [TAG_W-1:0]    key_tag_q;
	logic [NODE_W-1:0]   key_node_q;
	logic [AW-1:0]       idx_s1;
	logic [AW-1:0]       hit_idx_q;
	logic [STATUS_W-1:0] res_status_q;
	brlmf_rec_t          res_q;

	brlmf_rec_t rd_rec;
	brlmf_rec_t in_rec;
	logic       full;
	logic       issue;
	logic       hit;
	logic       better;
	logic       scan_end;
	logic       add_wr;

	assign rd_rec = brlmf_rec_t'(ram_rdata);
	assign in_rec = '{tag: record_tag, node: node_id, cost: cost};
	assign full   = (count_q == CAP_CNT);
	assign busy   = (state_q != S_IDLE);

	// Scan compare on the entry returned by the RAM
	assign hit = vld_s1 &&
		(((op_q == OP_FIND) && (rd_rec.node == key_node_q)) ||
		 ((op_q == OP_REMOVE) && (rd_rec.tag == key_tag_q)));
	assign better = vld_s1 && (op_q == OP_MIN) &&
		(!has_best_q || (rd_rec.cost < res_q.cost));
	assign issue    = (state_q == S_SCAN) && (iss_q != count_q) && !hit;
	assign scan_end = !vld_s1 && (iss_q == count_q);
	assign add_wr   = req_take && (op == OP_ADD) && !full;

	// RAM port steering
	always_comb begin
		ram_re    = issue || (state_q == S_MVRD);
		ram_raddr = (state_q == S_MVRD) ? count_q[AW-1:0] : iss_q[AW-1:0];
		ram_we    = add_wr || (state_q == S_MVWR);
		ram_waddr = (state_q == S_MVWR) ? hit_idx_q : count_q[AW-1:0];
		ram_wdata = (state_q == S_MVWR) ? ram_rdata : REC_W'(in_rec);
	end

	// Present the finished result
	always_comb begin
		rsp.valid  = (state_q == S_FIN);
		rsp.status = res_status_q;
		rsp.tag    = res_q.tag;
		rsp.node   = res_q.node;
		rsp.cost   = res_q.cost;
		rsp.count  = COUNT_W'(count_q);
	end

	// Advance the control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			iss_q      <= '0;
			vld_s1     <= 1'b0;
			has_best_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					vld_s1     <= 1'b0;
					iss_q      <= '0;
					has_best_q <= 1'b0;
					if (req_take) begin
						unique case (op)
							OP_ADD: begin
								if (!full) begin
									count_q <= count_q + 1'b1;
								end
								state_q <= S_FIN;
							end
							OP_REMOVE, OP_FIND, OP_MIN: begin
								state_q <= S_SCAN;
							end
							OP_CLEAR: begin
								count_q <= '0;
								state_q <= S_FIN;
							end
							default: begin
								state_q <= S_FIN;
							end
						endcase
					end
				end
				S_SCAN: begin
					vld_s1 <= issue;
					if (issue) begin
						iss_q <= iss_q + 1'b1;
					end
					if (better) begin
						has_best_q <= 1'b1;
					end
					if (hit) begin
						if (op_q == OP_REMOVE) begin
							count_q <= count_q - 1'b1;
							state_q <= S_MVRD;
						end else begin
							state_q <= S_FIN;
						end
					end else if (scan_end) begin
						state_q <= S_FIN;
					end
				end
				S_MVRD: begin
					state_q <= S_MVWR;
				end
				S_MVWR: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (rsp_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Capture keys and build the result fields
	always_ff @(posedge clk) begin
		idx_s1 <= iss_q[AW-1:0];
		if ((state_q == S_IDLE) && req_take) begin
			op_q       <= op;
			key_tag_q  <= record_tag;
			key_node_q <= node_id;
			res_q      <= '0;
			unique case (op)
				OP_ADD:    res_status_q <= full ? STAT_FULL : STAT_DONE;
				OP_CLEAR:  res_status_q <= STAT_DONE;
				default:   res_status_q <= STAT_MISS;
			endcase
		end
		if (state_q == S_SCAN) begin
			if (better) begin
				res_q <= rd_rec;
			end
			if (hit) begin
				hit_idx_q    <= idx_s1;
				res_status_q <= STAT_DONE;
				if (op_q == OP_FIND) begin
					res_q <= rd_rec;
				end
			end else if (scan_end) begin
				res_status_q <= ((op_q == OP_MIN) && has_best_q) ? STAT_DONE : STAT_MISS;
			end
		end
	end

endmodule

### design/bounded_record_list_min_find_core.sv
// ----------------------------------------------------------------------------
// bounded_record_list_min_find_core
// Fixed-capacity unsorted record list with add, remove, find and minimum.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall) carries one operation per item:
//   add, remove by tag, find by node, minimum cost, or clear. The block takes
//   one item at a time; req_stall stays high from acceptance until the
//   result has been moved into the output register.
//   Result channel (rsp_valid / rsp_stall) returns exactly one item per
//   request: status, the matched or minimum record, and the entry count.
//   Add, clear and unknown codes go to the finish state on acceptance.
//   Find and minimum scan the held entries in order and finish at the end
//   of the scan (at once on an empty list, sooner on an early find match);
//   remove scans the same way, stops on a tag match, then moves the last
//   entry into the freed slot. The finished result loads the output
//   register, and the next item is taken after the load. The scan reads the
//   single record RAM read port one entry per cycle, so scans grow with n.
//   Reset clears the entry count and all control state; record contents are
//   not cleared and need no clearing pass.
//   A stalled result holds in the output register; a finished next item
//   waits in the sequencer until the register frees up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bounded_record_list_min_find_core #(
	parameter int CAPACITY = brlmf_pkg::CAPACITY_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_stall,
	input  logic [brlmf_pkg::OP_W-1:0]       op,
	input  logic [brlmf_pkg::TAG_W-1:0]      record_tag,
	input  logic [brlmf_pkg::NODE_W-1:0]     node_id,
	input  logic [brlmf_pkg::COST_W-1:0]     cost,
	output logic                             rsp_valid,
	input  logic                             rsp_stall,
	output logic [brlmf_pkg::STATUS_W-1:0]   status,
	output logic [brlmf_pkg::TAG_W-1:0]      found_tag,
	output logic [brlmf_pkg::NODE_W-1:0]     found_node,
	output logic [brlmf_pkg::COST_W-1:0]     found_cost,
	output logic [brlmf_pkg::COUNT_W-1:0]    entry_count
);

	import brlmf_pkg::*;

	localparam int AW    = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic             busy;
	logic             req_take;
	logic             rsp_take;
	brlmf_rsp_t       rsp;
	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [REC_W-1:0] ram_wdata;
	logic             ram_re;
	logic [AW-1:0]    ram_raddr;
	logic [REC_W-1:0] ram_rdata;
	logic             out_vld_q;
	brlmf_rsp_t       out_q;

	assign req_stall = busy;
	assign req_take  = req_valid && !busy;
	assign rsp_take  = rsp.valid && (!out_vld_q || !rsp_stall);

	brlmf_seq #(
		.CAPACITY (CAPACITY),
		.AW       (AW),
		.CNT_W    (CNT_W)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_take   (req_take),
		.op         (op),
		.record_tag (record_tag),
		.node_id    (node_id),
		.cost       (cost),
		.busy       (busy),
		.rsp        (rsp),
		.rsp_take   (rsp_take),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.ram_re     (ram_re),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata)
	);

	brlmf_ram #(
		.WIDTH (REC_W),
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Output register valid: load on take, drop when delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (rsp_take) begin
			out_vld_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (rsp_take) begin
			out_q <= rsp;
		end
	end

	assign rsp_valid   = out_vld_q;
	assign status      = out_q.status;
	assign found_tag   = out_q.tag;
	assign found_node  = out_q.node;
	assign found_cost  = out_q.cost;
	assign entry_count = out_q.count;

	// Accepted request keeps the block busy in the next cycle
	`ASSERT_NEXT(a_busy_after_take, clk, arst_n, req_valid && !req_stall, req_stall)
	// A pending result waits unchanged until the output register takes it
	`ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp.valid && !rsp_take, rsp.valid && $stable(rsp))
	// A full status always reports the list at capacity
	`ASSERT_SAME(a_full_count, clk, arst_n, rsp_valid && (status == STAT_FULL),
		entry_count == COUNT_W'(CAPACITY))

endmodule
